>>> hw/rtl/nif_pkg.sv
// ----------------------------------------------------------------------------
// nif_pkg - shared constants and types for the impact force pipeline
// Register indexes, fixed-point constants and the flag bundle that travels
// with each request through the arithmetic stages.
// ----------------------------------------------------------------------------
`default_nettype none

package nif_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_STIFFNESS = 2'd0;
    localparam logic [1:0] REG_DAMPING   = 2'd1;
    localparam logic [1:0] REG_SHAPE     = 2'd2;

    // register reset values
    localparam logic [31:0] STIFFNESS_RST = 32'd0;
    localparam logic [31:0] DAMPING_RST   = 32'd0;
    localparam logic [15:0] SHAPE_ONE     = 16'd4096;

    // pipeline geometry
    localparam int unsigned NUM_STAGES = 28;
    localparam int unsigned LOG_STEPS  = 16;

    // fixed-point constants
    localparam logic [16:0] ONE_Q16   = 17'd65536;
    localparam logic [16:0] EXP_C1    = 17'd43025;
    localparam logic [31:0] EXP_C2    = 32'd22511;
    localparam logic [5:0]  LOG_BIAS  = 6'd24;
    localparam logic [57:0] D_ONE     = 58'h1_0000_0000;
    // right shift of the product held as Q*2^32 is 80 - integer exponent
    localparam logic signed [11:0] SHIFT_BIAS = 12'sd80;
    localparam logic [7:0]  SHIFT_MAX = 8'd255;

    // product and shifter widths
    localparam int unsigned PROD_W = 106;
    localparam int unsigned WIDE_W = PROD_W + 32;

    // saturation limits
    localparam logic [31:0] LIMIT_POS = 32'h7FFF_FFFF;
    localparam logic [31:0] LIMIT_NEG = 32'h8000_0000;

    // per-request flags carried down the pipeline
    typedef struct packed {
        logic contact;
        logic neg;
    } flags_t;

endpackage

`default_nettype wire

>>> hw/rtl/nonlinear_impact_force.sv
// ----------------------------------------------------------------------------
// nonlinear_impact_force - Hunt-Crossley contact force pipeline
// Streaming block: two contact point positions and velocities in, the
// saturated impact force and a contact flag out.
//
// Input channel s_*: one request carries both positions and velocities,
// signed Q8.24. Output channel m_*: contact force in signed Q16.16 on tdata,
// contact flag on tuser. Configuration is a plain write port, written only
// while the block is idle; the user must keep to this, it is not enforced.
// Throughput: one request per clock while the skid register is empty. The
// datapath is a 28-stage pipeline; the sixteen squaring steps of the base-2
// logarithm, one 32x32 multiply per stage, set most of that depth.
// Reset: aresetn clears all valid bits and loads the register defaults
// (stiffness 0, damping 0, shape 1.0).
// Stall: an output register plus a one-entry skid register absorb the last
// stage, so s_tready stays high while one finished result waits; s_tready
// drops only once the skid register is holding a result.
// ----------------------------------------------------------------------------
`default_nettype none

module nonlinear_impact_force
    import nif_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // configuration write port
    input  wire logic         cfg_wr_en,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [31:0]  cfg_wdata,
    // input stream
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // first_position, second_position, first_velocity, second_velocity
    input  wire logic [127:0] s_tdata,
    // result stream
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // contact_force
    output logic [31:0]       m_tdata,
    // in_contact
    output logic              m_tuser
);

    // ------------------------------------------------------------------------
    // declarations
    // ------------------------------------------------------------------------
    logic [31:0] stiff_reg;
    logic [31:0] damp_reg;
    logic [15:0] shape_reg;
    logic [15:0] alpha_eff;

    logic                  pipe_en;
    logic [NUM_STAGES-1:0] vld_reg;

    // stage 0: differences
    logic signed [32:0] s0_p_reg;
    logic signed [32:0] s0_v_reg;
    logic signed [32:0] s0_p_next;
    logic signed [32:0] s0_v_next;

    // stage 1: leading one, damping product
    logic [31:0]        s1_pos_reg;
    logic [4:0]         s1_e_reg;
    logic [4:0]         s1_e_next;
    logic               s1_contact_reg;
    logic signed [24:0] s1_vq;
    logic signed [57:0] s1_dprod_reg;
    logic signed [57:0] s1_dprod_next;

    // stage 2: normalise, damping term
    logic [31:0]        s2_x_reg;
    logic [4:0]         s2_e_reg;
    logic               s2_contact_reg;
    logic signed [57:0] s2_d_reg;

    // logarithm squaring stages
    logic [31:0] lg_xi     [LOG_STEPS];
    logic [15:0] lg_fi     [LOG_STEPS];
    logic [4:0]  lg_ei     [LOG_STEPS];
    flags_t      lg_gi     [LOG_STEPS];
    logic [56:0] lg_di     [LOG_STEPS];
    logic [63:0] lg_sq     [LOG_STEPS];
    logic [31:0] lg_x_next [LOG_STEPS];
    logic [15:0] lg_f_next [LOG_STEPS];
    logic [31:0] lg_x_reg  [LOG_STEPS];
    logic [15:0] lg_f_reg  [LOG_STEPS];
    logic [4:0]  lg_e_reg  [LOG_STEPS];
    flags_t      lg_g_reg  [LOG_STEPS];
    logic [56:0] lg_d_reg  [LOG_STEPS];

    // exponent scaling
    logic signed [21:0] al_l;
    logic signed [38:0] al_prod_reg;
    flags_t             al_g_reg;
    logic [56:0]        al_d_reg;

    // exp2 polynomial, first product
    logic [31:0]        e1_t1;
    logic [15:0]        e1_t1_reg;
    logic [15:0]        e1_f_reg;
    logic signed [10:0] e1_yi_reg;
    flags_t             e1_g_reg;
    logic [56:0]        e1_d_reg;

    // exp2 polynomial, second product and shift amount
    logic [16:0]        e2_sum;
    logic [32:0]        e2_t2;
    logic signed [11:0] e2_sv;
    logic [7:0]         e2_shamt_next;
    logic [16:0]        e2_m_reg;
    logic [7:0]         e2_shamt_reg;
    flags_t             e2_g_reg;
    logic [56:0]        e2_d_reg;

    // stiffness product
    logic [48:0] am_a_reg;
    logic [7:0]  am_shamt_reg;
    flags_t      am_g_reg;
    logic [56:0] am_d_reg;

    // partial products
    logic [53:0] pp00_reg;
    logic [52:0] pp01_reg;
    logic [52:0] pp10_reg;
    logic [51:0] pp11_reg;
    logic [7:0]  pp_shamt_reg;
    flags_t      pp_g_reg;

    // partial sums
    logic [82:0] sm_lo_reg;
    logic [81:0] sm_hi_reg;
    logic [7:0]  sm_shamt_reg;
    flags_t      sm_g_reg;

    // full product
    logic [106:0]      q_sum;
    logic [PROD_W-1:0] q_reg;
    logic [7:0]        q_shamt_reg;
    flags_t            q_g_reg;

    // shifter
    logic [WIDE_W-1:0] sh1_w_reg;
    logic [3:0]        sh1_lo_reg;
    flags_t            sh1_g_reg;
    logic [WIDE_W-1:0] sh2_w;
    logic              sh2_ovf_reg;
    logic [31:0]       sh2_low_reg;
    flags_t            sh2_g_reg;

    // saturation and sign
    logic [31:0] fin_limit;
    logic        fin_sat;
    logic [31:0] fin_mag;
    logic [31:0] fin_force;
    logic        fin_contact;

    // output and skid registers
    logic        out_vld_reg;
    logic [31:0] out_force_reg;
    logic        out_contact_reg;
    logic        skid_vld_reg;
    logic [31:0] skid_force_reg;
    logic        skid_contact_reg;

    // ------------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stiff_reg <= STIFFNESS_RST;
            damp_reg  <= DAMPING_RST;
            shape_reg <= SHAPE_ONE;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_STIFFNESS: stiff_reg <= cfg_wdata;
                REG_DAMPING:   damp_reg  <= cfg_wdata;
                REG_SHAPE:     shape_reg <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // shape below one acts as one
    assign alpha_eff = (shape_reg < SHAPE_ONE) ? SHAPE_ONE : shape_reg;

    // ------------------------------------------------------------------------
    // pipeline control: whole pipe moves unless the skid register is full
    // ------------------------------------------------------------------------
    assign pipe_en  = !skid_vld_reg;
    assign s_tready = pipe_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (pipe_en) begin
            vld_reg <= {vld_reg[NUM_STAGES-2:0], s_tvalid};
        end
    end

    // ------------------------------------------------------------------------
    // stage 0: compression and relative velocity
    // ------------------------------------------------------------------------
    assign s0_p_next = 33'(signed'(s_tdata[63:32])) - 33'(signed'(s_tdata[31:0]));
    assign s0_v_next = 33'(signed'(s_tdata[127:96])) - 33'(signed'(s_tdata[95:64]));

    // ------------------------------------------------------------------------
    // stage 1: top set bit of the compression, lambda times velocity
    // ------------------------------------------------------------------------
    always_comb begin
        s1_e_next = '0;
        for (int i = 0; i < 32; i++) begin
            if (s0_p_reg[i]) begin
                s1_e_next = 5'(i);
            end
        end
    end

    assign s1_vq         = s0_v_reg[32:8];
    assign s1_dprod_next = 58'($signed({1'b0, damp_reg})) * 58'(s1_vq);

    // ------------------------------------------------------------------------
    // logarithm: one squaring per stage, one fraction bit per stage
    // ------------------------------------------------------------------------
    always_comb begin
        lg_xi[0] = s2_x_reg;
        lg_fi[0] = '0;
        lg_ei[0] = s2_e_reg;
        lg_gi[0].contact = s2_contact_reg;
        lg_gi[0].neg     = s2_d_reg[57];
        lg_di[0] = s2_d_reg[57] ? 57'(-s2_d_reg) : 57'(s2_d_reg);
        for (int j = 1; j < LOG_STEPS; j++) begin
            lg_xi[j] = lg_x_reg[j-1];
            lg_fi[j] = lg_f_reg[j-1];
            lg_ei[j] = lg_e_reg[j-1];
            lg_gi[j] = lg_g_reg[j-1];
            lg_di[j] = lg_d_reg[j-1];
        end
        for (int j = 0; j < LOG_STEPS; j++) begin
            lg_sq[j]     = 64'(lg_xi[j]) * 64'(lg_xi[j]);
            lg_x_next[j] = lg_sq[j][63] ? lg_sq[j][63:32] : lg_sq[j][62:31];
            lg_f_next[j] = {lg_fi[j][14:0], lg_sq[j][63]};
        end
    end

    // ------------------------------------------------------------------------
    // exponent scaling and exp2 polynomial
    // ------------------------------------------------------------------------
    // integer part (e - 24) above the sixteen fraction bits
    assign al_l  = $signed({{1'b0, lg_e_reg[LOG_STEPS-1]} - LOG_BIAS, lg_f_reg[LOG_STEPS-1]});

    assign e1_t1 = EXP_C2 * 32'(al_prod_reg[27:12]);

    assign e2_sum = 17'(e1_t1_reg) + EXP_C1;
    assign e2_t2  = 33'(e2_sum) * 33'(e1_f_reg);
    assign e2_sv  = SHIFT_BIAS - 12'(e1_yi_reg);

    always_comb begin
        if (e2_sv < 12'sd0) begin
            e2_shamt_next = '0;
        end else if (e2_sv > $signed({4'd0, SHIFT_MAX})) begin
            e2_shamt_next = SHIFT_MAX;
        end else begin
            e2_shamt_next = e2_sv[7:0];
        end
    end

    // full product from the four partial products
    assign q_sum = 107'(sm_lo_reg) + (107'(sm_hi_reg) << 25);

    // fine shift
    assign sh2_w = sh1_w_reg >> sh1_lo_reg;

    // ------------------------------------------------------------------------
    // datapath registers
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            // stage 0
            s0_p_reg <= s0_p_next;
            s0_v_reg <= s0_v_next;

            // stage 1
            s1_pos_reg     <= s0_p_reg[31:0];
            s1_e_reg       <= s1_e_next;
            s1_contact_reg <= (s0_p_reg > 33'sd0);
            s1_dprod_reg   <= s1_dprod_next;

            // stage 2
            s2_x_reg       <= s1_pos_reg << (5'd31 - s1_e_reg);
            s2_e_reg       <= s1_e_reg;
            s2_contact_reg <= s1_contact_reg;
            s2_d_reg       <= $signed(D_ONE) + s1_dprod_reg;

            // logarithm stages
            for (int j = 0; j < LOG_STEPS; j++) begin
                lg_x_reg[j] <= lg_x_next[j];
                lg_f_reg[j] <= lg_f_next[j];
                lg_e_reg[j] <= lg_ei[j];
                lg_g_reg[j] <= lg_gi[j];
                lg_d_reg[j] <= lg_di[j];
            end

            // alpha times log2
            al_prod_reg <= 39'($signed({1'b0, alpha_eff})) * 39'(al_l);
            al_g_reg    <= lg_g_reg[LOG_STEPS-1];
            al_d_reg    <= lg_d_reg[LOG_STEPS-1];

            // exp2 first product, split into integer and fraction
            e1_t1_reg <= e1_t1[31:16];
            e1_f_reg  <= al_prod_reg[27:12];
            e1_yi_reg <= al_prod_reg[38:28];
            e1_g_reg  <= al_g_reg;
            e1_d_reg  <= al_d_reg;

            // exp2 mantissa and shift amount
            e2_m_reg     <= ONE_Q16 + e2_t2[32:16];
            e2_shamt_reg <= e2_shamt_next;
            e2_g_reg     <= e1_g_reg;
            e2_d_reg     <= e1_d_reg;

            // stiffness times mantissa
            am_a_reg     <= 49'(stiff_reg) * 49'(e2_m_reg);
            am_shamt_reg <= e2_shamt_reg;
            am_g_reg     <= e2_g_reg;
            am_d_reg     <= e2_d_reg;

            // partial products of the force magnitude
            pp00_reg     <= 54'(am_a_reg[24:0])  * 54'(am_d_reg[28:0]);
            pp01_reg     <= 53'(am_a_reg[24:0])  * 53'(am_d_reg[56:29]);
            pp10_reg     <= 53'(am_a_reg[48:25]) * 53'(am_d_reg[28:0]);
            pp11_reg     <= 52'(am_a_reg[48:25]) * 52'(am_d_reg[56:29]);
            pp_shamt_reg <= am_shamt_reg;
            pp_g_reg     <= am_g_reg;

            // partial sums
            sm_lo_reg    <= 83'(pp00_reg) + (83'(pp01_reg) << 29);
            sm_hi_reg    <= 82'(pp10_reg) + (82'(pp11_reg) << 29);
            sm_shamt_reg <= pp_shamt_reg;
            sm_g_reg     <= pp_g_reg;

            // full product
            q_reg       <= q_sum[PROD_W-1:0];
            q_shamt_reg <= sm_shamt_reg;
            q_g_reg     <= sm_g_reg;

            // coarse shift by multiples of sixteen
            sh1_w_reg  <= {q_reg, 32'd0} >> {q_shamt_reg[7:4], 4'd0};
            sh1_lo_reg <= q_shamt_reg[3:0];
            sh1_g_reg  <= q_g_reg;

            // fine shift, overflow detect
            sh2_ovf_reg <= |sh2_w[WIDE_W-1:32];
            sh2_low_reg <= sh2_w[31:0];
            sh2_g_reg   <= sh1_g_reg;
        end
    end

    // ------------------------------------------------------------------------
    // saturation, sign and no-contact zeroing
    // ------------------------------------------------------------------------
    assign fin_limit   = sh2_g_reg.neg ? LIMIT_NEG : LIMIT_POS;
    assign fin_sat     = sh2_ovf_reg || (sh2_low_reg > fin_limit);
    assign fin_mag     = fin_sat ? fin_limit : sh2_low_reg;
    assign fin_contact = sh2_g_reg.contact;

    always_comb begin
        if (!fin_contact) begin
            fin_force = '0;
        end else if (sh2_g_reg.neg) begin
            fin_force = ~fin_mag + 32'd1;
        end else begin
            fin_force = fin_mag;
        end
    end

    // ------------------------------------------------------------------------
    // output register with skid entry
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (skid_vld_reg) begin
            if (m_tready) begin
                skid_vld_reg <= 1'b0;
            end
        end else if (vld_reg[NUM_STAGES-1]) begin
            if (!out_vld_reg || m_tready) begin
                out_vld_reg <= 1'b1;
            end else begin
                skid_vld_reg <= 1'b1;
            end
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (skid_vld_reg) begin
            if (m_tready) begin
                out_force_reg   <= skid_force_reg;
                out_contact_reg <= skid_contact_reg;
            end
        end else begin
            skid_force_reg   <= fin_force;
            skid_contact_reg <= fin_contact;
            if (!out_vld_reg || m_tready) begin
                out_force_reg   <= fin_force;
                out_contact_reg <= fin_contact;
            end
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_force_reg;
    assign m_tuser  = out_contact_reg;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    // the skid entry is only ever occupied behind a held result
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid entry full while output register empty");

    // the skid entry fills only when the held result was not taken
    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_vld_reg) |-> $past(out_vld_reg && !m_tready))
        else $error("skid entry filled without an output stall");

    // no contact gives zero force
    a_no_contact_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == 32'd0))
        else $error("nonzero force reported without contact");

endmodule

`default_nettype wire
